>>> rtl/core/tai_pkg.sv
// shared types, constants and codes of the tilt and impact indicator
package tai_pkg;

  localparam int unsigned AccelWidth = 16;
  localparam int unsigned LevelWidth = 7;
  localparam int unsigned DeadZoneWidth = 15;
  localparam int unsigned ThreshWidth = 32;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_TILT = 2'd1;
  localparam logic [1:0] MODE_IMPACT = 2'd2;

  localparam logic [CfgIndexWidth-1:0] CFG_DEAD_ZONE = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_THRESHOLD = 2'd1;

  localparam logic [DeadZoneWidth-1:0] DEAD_ZONE_RESET = 15'd1000;
  localparam logic [ThreshWidth-1:0] THRESHOLD_RESET = 32'h4000_0000;

  localparam logic [LevelWidth-1:0] FULL_LEVEL = 7'd100;

  // level = floor(mag * 100 / 11586), exact for mag below the saturation point
  localparam int unsigned TiltMagWidth = 14;
  localparam int unsigned TiltMulWidth = 21;
  localparam int unsigned TiltShift = 27;
  localparam logic [TiltMulWidth-1:0] TILT_MUL = 21'd1158448;
  localparam logic [AccelWidth-1:0] TILT_SAT_MAG = 16'd11702;

  typedef struct packed {
    logic                   button_level;
    logic                   sample_valid;
    logic signed [AccelWidth-1:0] accel_x;
    logic signed [AccelWidth-1:0] accel_y;
    logic signed [AccelWidth-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [LevelWidth-1:0] green_level;
    logic [LevelWidth-1:0] orange_level;
    logic [LevelWidth-1:0] red_level;
    logic [LevelWidth-1:0] blue_level;
    logic                  impact_now;
  } out_item_t;

  typedef struct packed {
    logic [LevelWidth-1:0] pos_level;
    logic [LevelWidth-1:0] neg_level;
  } axis_levels_t;

endpackage

>>> rtl/core/tai_axis.sv
// tilt levels of one axis: dead zone test and scaled, saturated magnitude
module tai_axis import tai_pkg::*; (
  input  logic signed [AccelWidth-1:0]    accel_i,
  input  logic        [DeadZoneWidth-1:0] dead_zone_i,
  output axis_levels_t                    levels_o
);

  logic signed [AccelWidth:0]                   accel_ext;
  logic signed [AccelWidth:0]                   dz_pos;
  logic signed [AccelWidth:0]                   dz_neg;
  logic        [AccelWidth-1:0]                 mag;
  logic        [TiltMagWidth+TiltMulWidth-1:0]  prod;
  logic        [LevelWidth-1:0]                 level;

  assign accel_ext = {accel_i[AccelWidth-1], accel_i};
  assign dz_pos    = $signed({2'b00, dead_zone_i});
  assign dz_neg    = -dz_pos;
  assign mag       = accel_i[AccelWidth-1] ? AccelWidth'(-accel_i) : AccelWidth'(accel_i);
  assign prod      = mag[TiltMagWidth-1:0] * TILT_MUL;
  assign level     = (mag >= TILT_SAT_MAG) ? FULL_LEVEL : prod[TiltShift +: LevelWidth];

  always_comb begin
    levels_o = '0;
    if (accel_ext > dz_pos) begin
      levels_o.pos_level = level;
    end else if (accel_ext < dz_neg) begin
      levels_o.neg_level = level;
    end
  end

endmodule

>>> rtl/core/tai_impact.sv
// squared magnitude of a sample against the impact threshold
module tai_impact import tai_pkg::*; (
  input  logic signed [AccelWidth-1:0]  accel_x_i,
  input  logic signed [AccelWidth-1:0]  accel_y_i,
  input  logic signed [AccelWidth-1:0]  accel_z_i,
  input  logic        [ThreshWidth-1:0] threshold_i,
  output logic                          over_o
);

  logic signed [2*AccelWidth-1:0] sq_x;
  logic signed [2*AccelWidth-1:0] sq_y;
  logic signed [2*AccelWidth-1:0] sq_z;
  logic        [ThreshWidth-1:0]  sum;

  assign sq_x   = accel_x_i * accel_x_i;
  assign sq_y   = accel_y_i * accel_y_i;
  assign sq_z   = accel_z_i * accel_z_i;
  assign sum    = ThreshWidth'($unsigned(sq_x)) + ThreshWidth'($unsigned(sq_y))
                + ThreshWidth'($unsigned(sq_z));
  assign over_o = sum > threshold_i;

endmodule

>>> rtl/core/tilt_and_impact_indicator_core.sv
// top level: item registers, mode and light state, configuration registers
// One item is accepted per clock cycle, unless a result waits in the output register
// while out_ready_i is low. Each accepted item is held in an input register, where the
// tilt levels, the squared magnitude test and the mode step are worked out against the
// current state; when the item advances, the result and the new mode and light state are
// registered together, and the input register may take the next item at that same edge.
// Configuration writes are always taken; an index outside the register list is ignored.
module tilt_and_impact_indicator_core import tai_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  logic                     in_valid_q;
  in_item_t                 in_item_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;
  logic                     advance;

  logic [DeadZoneWidth-1:0] dead_zone_q;
  logic [ThreshWidth-1:0]   threshold_q;

  logic [1:0]               mode_q, mode_d;
  logic                     prev_button_q, prev_button_d;
  logic                     press_q, press_d;
  logic                     impact_q, impact_d;
  logic [LevelWidth-1:0]    green_q, green_d;
  logic [LevelWidth-1:0]    orange_q, orange_d;
  logic [LevelWidth-1:0]    red_q, red_d;
  logic [LevelWidth-1:0]    blue_q, blue_d;

  axis_levels_t             x_levels;
  axis_levels_t             y_levels;
  logic                     over;
  logic                     hit;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  tai_axis u_axis_x (
    .accel_i     (in_item_q.accel_x),
    .dead_zone_i (dead_zone_q),
    .levels_o    (x_levels)
  );

  tai_axis u_axis_y (
    .accel_i     (in_item_q.accel_y),
    .dead_zone_i (dead_zone_q),
    .levels_o    (y_levels)
  );

  tai_impact u_impact (
    .accel_x_i   (in_item_q.accel_x),
    .accel_y_i   (in_item_q.accel_y),
    .accel_z_i   (in_item_q.accel_z),
    .threshold_i (threshold_q),
    .over_o      (over)
  );

  assign hit = in_item_q.sample_valid && over;

  always_comb begin
    mode_d        = mode_q;
    prev_button_d = in_item_q.button_level;
    press_d       = press_q || (in_item_q.button_level && !prev_button_q);
    impact_d      = impact_q;
    green_d       = green_q;
    orange_d      = orange_q;
    red_d         = red_q;
    blue_d        = blue_q;
    if (in_item_q.sample_valid) begin
      if (mode_q == MODE_TILT) begin
        red_d    = x_levels.pos_level;
        green_d  = x_levels.neg_level;
        orange_d = y_levels.pos_level;
        blue_d   = y_levels.neg_level;
      end
      if (hit) begin
        impact_d = 1'b1;
      end
      case (mode_q)
        MODE_OFF: begin
          if (press_d) begin
            press_d = 1'b0;
            mode_d  = MODE_TILT;
          end
        end
        MODE_TILT: begin
          if (press_d) begin
            press_d  = 1'b0;
            mode_d   = MODE_IMPACT;
            green_d  = '0;
            orange_d = '0;
            red_d    = '0;
            blue_d   = '0;
          end
        end
        MODE_IMPACT: begin
          if (impact_d) begin
            impact_d = 1'b0;
            green_d  = FULL_LEVEL;
            orange_d = FULL_LEVEL;
            red_d    = FULL_LEVEL;
            blue_d   = FULL_LEVEL;
          end
          if (press_d) begin
            press_d  = 1'b0;
            mode_d   = MODE_OFF;
            green_d  = '0;
            orange_d = '0;
            red_d    = '0;
            blue_d   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      dead_zone_q   <= DEAD_ZONE_RESET;
      threshold_q   <= THRESHOLD_RESET;
      mode_q        <= MODE_OFF;
      prev_button_q <= 1'b0;
      press_q       <= 1'b0;
      impact_q      <= 1'b0;
      green_q       <= '0;
      orange_q      <= '0;
      red_q         <= '0;
      blue_q        <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DEAD_ZONE: dead_zone_q <= cfg_data_i[DeadZoneWidth-1:0];
          CFG_THRESHOLD: threshold_q <= cfg_data_i[ThreshWidth-1:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        mode_q        <= mode_d;
        prev_button_q <= prev_button_d;
        press_q       <= press_d;
        impact_q      <= impact_d;
        green_q       <= green_d;
        orange_q      <= orange_d;
        red_q         <= red_d;
        blue_q        <= blue_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q.mode         <= mode_d;
      out_item_q.green_level  <= green_d;
      out_item_q.orange_level <= orange_d;
      out_item_q.red_level    <= red_d;
      out_item_q.blue_level   <= blue_d;
      out_item_q.impact_now   <= hit;
    end
  end

  // lights stay dark while off
  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_OFF |-> (green_q == '0 && orange_q == '0 && red_q == '0 && blue_q == '0))
    else $error("lights lit in off mode");

  // mode only moves on a sampled item
  a_mode_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_item_q.sample_valid) |=> $stable(mode_q))
    else $error("mode changed without a sample");

  // a sampled item in impact mode consumes the pending impact
  a_impact_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_item_q.sample_valid && mode_q == MODE_IMPACT |=> !impact_q)
    else $error("impact still pending after impact-mode sample");

  // an empty result register never blocks input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

>>> verif/tb_tilt_and_impact_indicator_core.sv
// testbench for the tilt and impact indicator core: directed and random items with a display predictor
module tb_tilt_and_impact_indicator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tai_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TILT_FULL_SCALE = 11586;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 235;

  localparam int LIGHT_GREEN = 0;
  localparam int LIGHT_ORANGE = 1;
  localparam int LIGHT_RED = 2;
  localparam int LIGHT_BLUE = 3;

  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_B = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready_o;
  in_item_t in_item = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  tilt_and_impact_indicator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  in_item_t sample_q[$];
  out_item_t display_q[$];

  int unsigned err_cnt = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_writes = 0;
  int unsigned n_hits = 0;
  int unsigned n_tilt = 0;
  int unsigned idle_cycles = 0;

  // predicted block state
  logic [1:0] exp_mode = MODE_OFF;
  logic exp_prev_btn = 1'b0;
  logic exp_press = 1'b0;
  logic exp_impact = 1'b0;
  logic [LevelWidth-1:0] exp_lvl[4] = '{default: '0};
  logic [DeadZoneWidth-1:0] exp_dead_zone = DEAD_ZONE_RESET;
  logic [ThreshWidth-1:0] exp_threshold = THRESHOLD_RESET;

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [LevelWidth-1:0] tilt_pct(int unsigned mag);
    int unsigned pct;
    pct = mag * 100 / TILT_FULL_SCALE;
    return (pct > FULL_LEVEL) ? FULL_LEVEL : LevelWidth'(pct);
  endfunction

  function automatic void tilt_axis(int a, int pos_i, int neg_i);
    int dz;
    dz = int'(exp_dead_zone);
    if (a > dz) begin
      exp_lvl[pos_i] = tilt_pct(a);
      exp_lvl[neg_i] = '0;
    end else if (a < -dz) begin
      exp_lvl[neg_i] = tilt_pct(-a);
      exp_lvl[pos_i] = '0;
    end else begin
      exp_lvl[pos_i] = '0;
      exp_lvl[neg_i] = '0;
    end
  endfunction

  function automatic void set_all_lights(logic [LevelWidth-1:0] v);
    for (int i = 0; i < 4; i++) exp_lvl[i] = v;
  endfunction

  function automatic out_item_t predict_display(in_item_t it);
    out_item_t r;
    int ax;
    int ay;
    int az;
    logic [31:0] sq;
    logic hit;
    hit = 1'b0;
    if (it.button_level && !exp_prev_btn) exp_press = 1'b1;
    exp_prev_btn = it.button_level;
    if (it.sample_valid) begin
      ax = int'($signed(it.accel_x));
      ay = int'($signed(it.accel_y));
      az = int'($signed(it.accel_z));
      if (exp_mode == MODE_TILT) begin
        tilt_axis(ax, LIGHT_RED, LIGHT_GREEN);
        tilt_axis(ay, LIGHT_ORANGE, LIGHT_BLUE);
      end
      sq = 32'(ax * ax) + 32'(ay * ay) + 32'(az * az);
      if (sq > exp_threshold) begin
        hit = 1'b1;
        exp_impact = 1'b1;
      end
      case (exp_mode)
        MODE_OFF: begin
          if (exp_press) begin
            exp_press = 1'b0;
            exp_mode = MODE_TILT;
          end
        end
        MODE_TILT: begin
          if (exp_press) begin
            exp_press = 1'b0;
            exp_mode = MODE_IMPACT;
            set_all_lights('0);
          end
        end
        MODE_IMPACT: begin
          if (exp_impact) begin
            exp_impact = 1'b0;
            set_all_lights(FULL_LEVEL);
          end
          if (exp_press) begin
            exp_press = 1'b0;
            exp_mode = MODE_OFF;
            set_all_lights('0);
          end
        end
        default: ;
      endcase
    end
    r.mode = exp_mode;
    r.green_level = exp_lvl[LIGHT_GREEN];
    r.orange_level = exp_lvl[LIGHT_ORANGE];
    r.red_level = exp_lvl[LIGHT_RED];
    r.blue_level = exp_lvl[LIGHT_BLUE];
    r.impact_now = hit;
    return r;
  endfunction

  function automatic in_item_t make_sample(bit btn, bit smp, int x, int y, int z);
    in_item_t it;
    it.button_level = btn;
    it.sample_valid = smp;
    it.accel_x = AccelWidth'(x);
    it.accel_y = AccelWidth'(y);
    it.accel_z = AccelWidth'(z);
    return it;
  endfunction

  // mix of full-range, dead zone edges, tilt range, rail and small values
  function automatic int pick_accel(int dz);
    int m;
    case ($urandom_range(0, 5))
      0: return int'($signed(AccelWidth'($urandom)));
      1: m = dz + int'($urandom_range(0, 2)) - 1;
      2: m = $urandom_range(0, 12000);
      3: m = $urandom_range(32760, 32768);
      default: m = $urandom_range(0, 1500);
    endcase
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // prediction at acceptance, register writes applied to the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        n_writes++;
        if (cfg_index == CFG_DEAD_ZONE) exp_dead_zone = cfg_data[DeadZoneWidth-1:0];
        else if (cfg_index == CFG_THRESHOLD) exp_threshold = cfg_data[ThreshWidth-1:0];
      end
      if (in_valid && in_ready_o) begin
        n_items++;
        display_q.push_back(predict_display(in_item));
      end
    end
  end

  // item driver
  bit tx_burst = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item <= '0;
      gap_left <= 0;
    end else if (!in_valid || in_ready_o) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() != 0) begin
        in_valid <= 1'b1;
        in_item <= sample_q.pop_front();
        gap_left <= draw_gap(tx_burst);
        if ($urandom_range(0, 40) == 0) tx_burst <= !tx_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  bit rx_burst = 1'b0;
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int unsigned n;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (display_q.size() == 0) begin
          $error("result with no item awaiting it: mode %0d", out_item_o.mode);
          err_cnt++;
        end else begin
          want = display_q.pop_front();
          n_checked++;
          if (want.impact_now) n_hits++;
          if (want.mode == MODE_TILT) n_tilt++;
          if (out_item_o.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, out_item_o.mode);
            err_cnt++;
          end
          if (out_item_o.green_level !== want.green_level) begin
            $error("green_level: expected %0d, got %0d", want.green_level,
                   out_item_o.green_level);
            err_cnt++;
          end
          if (out_item_o.orange_level !== want.orange_level) begin
            $error("orange_level: expected %0d, got %0d", want.orange_level,
                   out_item_o.orange_level);
            err_cnt++;
          end
          if (out_item_o.red_level !== want.red_level) begin
            $error("red_level: expected %0d, got %0d", want.red_level,
                   out_item_o.red_level);
            err_cnt++;
          end
          if (out_item_o.blue_level !== want.blue_level) begin
            $error("blue_level: expected %0d, got %0d", want.blue_level,
                   out_item_o.blue_level);
            err_cnt++;
          end
          if (out_item_o.impact_now !== want.impact_now) begin
            $error("impact_now: expected %0d, got %0d", want.impact_now,
                   out_item_o.impact_now);
            err_cnt++;
          end
        end
        n = draw_gap(rx_burst);
        if ($urandom_range(0, 40) == 0) rx_burst <= !rx_burst;
        out_ready <= (n == 0);
        stall_left <= n;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (sample_q.size() != 0 || in_valid || display_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int dz_plan;
    logic [ThreshWidth-1:0] thr_plan;
    bit btn;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: mode walk, dead zone edges, saturation, stale and fresh impacts
    sample_q.push_back(make_sample(0, 1, 32767, -32768, 0));
    sample_q.push_back(make_sample(1, 0, 0, 0, 0));
    sample_q.push_back(make_sample(1, 0, -1, -1, -1));
    sample_q.push_back(make_sample(0, 1, 0, 0, 0));
    sample_q.push_back(make_sample(0, 1, -32768, 32767, -32768));
    sample_q.push_back(make_sample(0, 1, 1001, -1001, 0));
    sample_q.push_back(make_sample(0, 1, 1000, -1000, 0));
    sample_q.push_back(make_sample(0, 1, -1001, 1000, 0));
    sample_q.push_back(make_sample(0, 1, 11586, -11585, 0));
    sample_q.push_back(make_sample(0, 1, -32768, 0, 0));
    sample_q.push_back(make_sample(0, 1, -32768, 1, 0));
    sample_q.push_back(make_sample(1, 1, 5793, 0, 0));
    sample_q.push_back(make_sample(0, 1, 0, 0, 0));
    sample_q.push_back(make_sample(0, 1, 100, 100, 100));
    sample_q.push_back(make_sample(1, 1, 32767, 32767, 32767));
    sample_q.push_back(make_sample(0, 1, 0, 0, 0));
    sample_q.push_back(make_sample(1, 1, 0, 0, 0));
    sample_q.push_back(make_sample(0, 0, 0, 0, 0));
    sample_q.push_back(make_sample(1, 1, 0, 0, -32768));
    sample_q.push_back(make_sample(0, 1, 0, 0, 0));
    sample_q.push_back(make_sample(0, 1, -32768, -32768, -32768));
    sample_q.push_back(make_sample(1, 0, 0, 0, 0));
    sample_q.push_back(make_sample(0, 1, 1, -1, 0));
    wait_drained();

    btn = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin dz_plan = 0; thr_plan = '0; end
        1: begin dz_plan = 32767; thr_plan = 32'hC000_0000; end
        2: begin dz_plan = int'(DEAD_ZONE_RESET); thr_plan = 32'hBFFF_FFFF; end
        default: begin
          dz_plan = $urandom_range(0, 12000);
          thr_plan = $urandom_range(0, 32'hC000_0000);
        end
      endcase
      // spare indexes must leave both registers alone
      write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
      write_reg(CFG_DEAD_ZONE, {17'($urandom), DeadZoneWidth'(dz_plan)});
      write_reg(CFG_THRESHOLD, thr_plan);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 5) == 0) btn = !btn;
        sample_q.push_back(make_sample(btn, $urandom_range(0, 4) != 0,
                                       pick_accel(dz_plan), pick_accel(dz_plan),
                                       pick_accel(dz_plan)));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d items and %0d register writes over %0d settings", n_items,
             n_writes, PHASES + 1);
    $display("checked %0d results: %0d with impact flagged, %0d in tilt mode", n_checked,
             n_hits, n_tilt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tai_pkg.sv
rtl/core/tai_axis.sv
rtl/core/tai_impact.sv
rtl/core/tilt_and_impact_indicator_core.sv
verif/tb_tilt_and_impact_indicator_core.sv
